// File: rtl/hbct_pkg.sv
// Shared types and constants of the hashed buffer cache tag unit.
// No dependencies; used by the tag RAM, the top level, the checker and the testbench.
package hbct_pkg;

    localparam int DEF_NUM_SLOTS   = 32;
    localparam int DEF_NUM_BUCKETS = 13;

    localparam int CMD_W    = 2;
    localparam int DEVICE_W = 16;
    localparam int BLOCK_W  = 32;
    localparam int SLOT_W   = 5;
    localparam int REFS_W   = 8;
    localparam int BUCKET_W = 4;
    localparam int STATUS_W = 2;

    localparam logic [REFS_W-1:0] REFS_MAX = '1;

    // block number is reduced mod bucket count one hex digit per cycle
    localparam int MOD_STEPS  = BLOCK_W / 4;
    localparam int MOD_STEP_W = $clog2(MOD_STEPS);

    // stream payload widths
    localparam int S_TDATA_W = 56;  // device, block_number, slot_in, pad
    localparam int S_TUSER_W = CMD_W;
    localparam int M_TDATA_W = 16;  // slot_out, hit, needs_fill, status, pad

    typedef enum logic [CMD_W-1:0] {
        CMD_GET     = 2'd0,
        CMD_RELEASE = 2'd1,
        CMD_PIN     = 2'd2,
        CMD_UNPIN   = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_NO_FREE   = 2'd1,
        STAT_UNDERFLOW = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_SCAN,
        ST_RD,
        ST_UPD
    } state_t;

    typedef struct packed {
        logic [DEVICE_W-1:0] device;
        logic [BLOCK_W-1:0]  block;
        logic [REFS_W-1:0]   refs;
        logic                valid;
        logic [BUCKET_W-1:0] bucket;
    } tag_rec_t;

endpackage

// File: rtl/hbct_tag_ram.sv
// Slot tag memory: one write port, one registered read port.
// Entries never written read back as their reset record. Uses hbct_pkg.
module hbct_tag_ram #(
    parameter int NUM_SLOTS   = hbct_pkg::DEF_NUM_SLOTS,
    parameter int NUM_BUCKETS = hbct_pkg::DEF_NUM_BUCKETS,
    localparam int IDX_W      = $clog2(NUM_SLOTS)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                rd_en,
    input  logic [IDX_W-1:0]    rd_addr,
    output hbct_pkg::tag_rec_t  rd_data,
    input  logic                wr_en,
    input  logic [IDX_W-1:0]    wr_addr,
    input  hbct_pkg::tag_rec_t  wr_data
);

    localparam int BKT_W = hbct_pkg::BUCKET_W;

    hbct_pkg::tag_rec_t mem [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] wr_mark_reg;
    logic [BKT_W-1:0]     init_bkt [NUM_SLOTS];

    hbct_pkg::tag_rec_t raw_reg;
    logic               mark_reg;
    logic [BKT_W-1:0]   ibkt_reg;

    // reset bucket of each slot: index mod bucket count
    for (genvar g = 0; g < NUM_SLOTS; g++)
    begin : g_init_bkt
        localparam int IB = g % NUM_BUCKETS;
        assign init_bkt[g] = BKT_W'(IB);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_mark_reg <= '0;
        end
        else if (wr_en)
        begin
            wr_mark_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            raw_reg  <= mem[rd_addr];
            mark_reg <= wr_mark_reg[rd_addr];
            ibkt_reg <= init_bkt[rd_addr];
        end
    end

    always_comb
    begin
        if (mark_reg)
        begin
            rd_data = raw_reg;
        end
        else
        begin
            rd_data        = '0;
            rd_data.bucket = ibkt_reg;
        end
    end

endmodule

// File: rtl/hashed_buffer_cache_tags_unit.sv
// Hashed buffer cache tag unit. One item in flight at a time; not ready while busy.
// get: reduce block_number mod NUM_BUCKETS (ST_MOD), scan with one tag RAM read per slot
//   (ST_SCAN), then update (ST_UPD).
// release/pin/unpin: tag RAM read (ST_RD), then update (ST_UPD).
//   A result held by m_axis_tready keeps the next item in its update cycle until it leaves.
// Reset (rst_n low, async): all slots free and invalid, slot s in bucket s mod NUM_BUCKETS.
module hashed_buffer_cache_tags_unit #(
    parameter int NUM_SLOTS   = hbct_pkg::DEF_NUM_SLOTS,
    parameter int NUM_BUCKETS = hbct_pkg::DEF_NUM_BUCKETS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // command item
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [15:0] device, [47:16] block_number, [52:48] slot_in, [55:53] zero
    input  logic [hbct_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // [1:0] cmd
    input  logic [hbct_pkg::S_TUSER_W-1:0]  s_axis_tuser,
    // result item
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [4:0] slot_out, [5] hit, [6] needs_fill, [8:7] status, [15:9] zero
    output logic [hbct_pkg::M_TDATA_W-1:0]  m_axis_tdata
);

    localparam int IDX_W    = $clog2(NUM_SLOTS);
    localparam int CNT_W    = IDX_W + 1;
    localparam int DEVICE_W = hbct_pkg::DEVICE_W;
    localparam int BLOCK_W  = hbct_pkg::BLOCK_W;
    localparam int SLOT_W   = hbct_pkg::SLOT_W;
    localparam int REFS_W   = hbct_pkg::REFS_W;
    localparam int BKT_W    = hbct_pkg::BUCKET_W;
    localparam int MSTEP_W  = hbct_pkg::MOD_STEP_W;
    localparam int PAD_W    = hbct_pkg::M_TDATA_W - SLOT_W - 2 - hbct_pkg::STATUS_W;

    localparam logic [5:0]       NB6      = 6'(NUM_BUCKETS);
    localparam logic [BKT_W:0]   NB5      = (BKT_W + 1)'(NUM_BUCKETS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);
    localparam logic [CNT_W-1:0] SLOT_CNT = CNT_W'(NUM_SLOTS);

    // (r * 16 + d) mod NUM_BUCKETS, two bits at a time; r < NUM_BUCKETS on entry
    function automatic logic [BKT_W-1:0] mod_digit(input logic [BKT_W-1:0] r,
                                                   input logic [3:0] d);
        logic [5:0] v;
        v = {2'b00, r};
        for (int j = 1; j >= 0; j--)
        begin
            v = {v[3:0], d[2*j+:2]};
            for (int k = 0; k < 3; k++)
            begin
                if (v >= NB6)
                begin
                    v = v - NB6;
                end
            end
        end
        return v[BKT_W-1:0];
    endfunction

    hbct_pkg::state_t state_reg, state_next;

    // captured item
    hbct_pkg::cmd_t       cmd_reg;
    logic [DEVICE_W-1:0]  dev_reg;
    logic [BLOCK_W-1:0]   blk_reg;
    logic [SLOT_W-1:0]    sin_reg;
    logic                 in_range_reg;

    // hash reduction
    logic [BLOCK_W-1:0]   blk_sh_reg;
    logic [MSTEP_W-1:0]   step_reg;
    logic [BKT_W-1:0]     bkt_reg;

    // scan
    logic [CNT_W-1:0]     cnt_reg;
    logic                 chk_vld_reg;
    logic [IDX_W-1:0]     chk_idx_reg;
    logic                 hit_found_reg;
    logic [IDX_W-1:0]     sel_idx_reg;
    logic [REFS_W-1:0]    sel_refs_reg;
    logic                 sel_valid_reg;
    logic                 cand_found_reg;
    logic [BKT_W-1:0]     cand_d_reg;
    logic [IDX_W-1:0]     cand_idx_reg;

    // result register
    logic                 out_valid_reg;
    logic [SLOT_W-1:0]    out_slot_reg;
    logic                 out_hit_reg;
    logic                 out_fill_reg;
    hbct_pkg::status_t    out_status_reg;

    // tag RAM port
    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    hbct_pkg::tag_rec_t   rd_data;
    logic                 wr_en;
    hbct_pkg::tag_rec_t   upd_rec;

    // update decode
    logic                 upd_wr;
    logic [IDX_W-1:0]     upd_addr;
    logic [SLOT_W-1:0]    res_slot;
    logic                 res_hit;
    logic                 res_fill;
    hbct_pkg::status_t    res_status;
    logic                 load_out;
    logic                 accept;

    // scan compare unit
    logic                 match;
    logic                 is_free;
    logic [BKT_W:0]       gap_w;
    logic [BKT_W-1:0]     gap;

    logic [CNT_W-1:0]     cnt_next;
    logic                 chk_vld_next;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == hbct_pkg::ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {PAD_W'(0), out_status_reg, out_fill_reg, out_hit_reg, out_slot_reg};

    hbct_tag_ram #(
        .NUM_SLOTS   (NUM_SLOTS),
        .NUM_BUCKETS (NUM_BUCKETS)
    ) u_tag_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (upd_addr),
        .wr_data (upd_rec)
    );

    // Shared compare unit: tag match and wrapping bucket distance of a free slot.
    // Distance 0 is the requested bucket; the steal order is increasing distance.
    always_comb
    begin
        match   = (rd_data.bucket == bkt_reg) && (rd_data.device == dev_reg) &&
                  (rd_data.block == blk_reg);
        is_free = (rd_data.refs == '0);
        if (rd_data.bucket >= bkt_reg)
        begin
            gap_w = {1'b0, rd_data.bucket} - {1'b0, bkt_reg};
        end
        else
        begin
            gap_w = {1'b0, rd_data.bucket} + NB5 - {1'b0, bkt_reg};
        end
        gap = gap_w[BKT_W-1:0];
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        rd_en      = 1'b0;
        rd_addr    = cnt_reg[IDX_W-1:0];
        load_out   = 1'b0;
        wr_en      = 1'b0;
        unique case (state_reg)
            hbct_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    if (hbct_pkg::cmd_t'(s_axis_tuser) == hbct_pkg::CMD_GET)
                    begin
                        state_next = hbct_pkg::ST_MOD;
                    end
                    else
                    begin
                        state_next = hbct_pkg::ST_RD;
                    end
                end
            end
            hbct_pkg::ST_MOD:
            begin
                if (step_reg == MSTEP_W'(hbct_pkg::MOD_STEPS - 1))
                begin
                    state_next = hbct_pkg::ST_SCAN;
                end
            end
            hbct_pkg::ST_SCAN:
            begin
                rd_en = (cnt_reg < SLOT_CNT);
                if (chk_vld_reg && (chk_idx_reg == LAST_IDX))
                begin
                    state_next = hbct_pkg::ST_UPD;
                end
            end
            hbct_pkg::ST_RD:
            begin
                rd_en      = in_range_reg;
                rd_addr    = IDX_W'(sin_reg);
                state_next = hbct_pkg::ST_UPD;
            end
            hbct_pkg::ST_UPD:
            begin
                // result register must be free before the slot is touched
                if (!out_valid_reg || m_axis_tready)
                begin
                    load_out   = 1'b1;
                    wr_en      = upd_wr;
                    state_next = hbct_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = hbct_pkg::ST_IDLE;
            end
        endcase
    end

    // Result and slot write-back
    always_comb
    begin
        upd_wr     = 1'b0;
        upd_addr   = IDX_W'(sin_reg);
        upd_rec    = rd_data;
        res_slot   = sin_reg;
        res_hit    = 1'b0;
        res_fill   = 1'b0;
        res_status = hbct_pkg::STAT_OK;
        if (cmd_reg == hbct_pkg::CMD_GET)
        begin
            upd_rec.device = dev_reg;
            upd_rec.block  = blk_reg;
            upd_rec.valid  = 1'b1;
            upd_rec.bucket = bkt_reg;
            priority if (hit_found_reg)
            begin
                upd_wr       = 1'b1;
                upd_addr     = sel_idx_reg;
                upd_rec.refs = (sel_refs_reg == hbct_pkg::REFS_MAX) ? sel_refs_reg :
                               sel_refs_reg + 1'b1;
                res_slot     = SLOT_W'(sel_idx_reg);
                res_hit      = 1'b1;
                res_fill     = !sel_valid_reg;
            end
            else if (cand_found_reg)
            begin
                upd_wr       = 1'b1;
                upd_addr     = cand_idx_reg;
                upd_rec.refs = REFS_W'(1);
                res_slot     = SLOT_W'(cand_idx_reg);
                res_fill     = 1'b1;
            end
            else
            begin
                res_slot   = '0;
                res_status = hbct_pkg::STAT_NO_FREE;
            end
        end
        else if (in_range_reg)
        begin
            if (cmd_reg == hbct_pkg::CMD_PIN)
            begin
                upd_wr = (rd_data.refs != hbct_pkg::REFS_MAX);
                upd_rec.refs = rd_data.refs + 1'b1;
            end
            else if (rd_data.refs == '0)
            begin
                res_status = hbct_pkg::STAT_UNDERFLOW;
            end
            else
            begin
                upd_wr       = 1'b1;
                upd_rec.refs = rd_data.refs - 1'b1;
            end
        end
    end

    assign chk_vld_next = rd_en && (state_reg == hbct_pkg::ST_SCAN);
    assign cnt_next     = cnt_reg + 1'b1;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= hbct_pkg::ST_IDLE;
            out_valid_reg  <= 1'b0;
            chk_vld_reg    <= 1'b0;
            hit_found_reg  <= 1'b0;
            cand_found_reg <= 1'b0;
            step_reg       <= '0;
            cnt_reg        <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            chk_vld_reg <= chk_vld_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (accept)
            begin
                hit_found_reg  <= 1'b0;
                cand_found_reg <= 1'b0;
                step_reg       <= '0;
                cnt_reg        <= '0;
            end
            else
            begin
                if (state_reg == hbct_pkg::ST_MOD)
                begin
                    step_reg <= step_reg + 1'b1;
                end
                if (chk_vld_next)
                begin
                    cnt_reg <= cnt_next;
                end
                if (chk_vld_reg && (state_reg == hbct_pkg::ST_SCAN))
                begin
                    if (match && !hit_found_reg)
                    begin
                        hit_found_reg <= 1'b1;
                    end
                    // strictly nearer bucket only: ties keep the lowest slot
                    if (is_free && (!cand_found_reg || (gap < cand_d_reg)))
                    begin
                        cand_found_reg <= 1'b1;
                    end
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg      <= hbct_pkg::cmd_t'(s_axis_tuser);
            dev_reg      <= s_axis_tdata[15:0];
            blk_reg      <= s_axis_tdata[47:16];
            blk_sh_reg   <= s_axis_tdata[47:16];
            sin_reg      <= s_axis_tdata[52:48];
            in_range_reg <= (32'(s_axis_tdata[52:48]) < NUM_SLOTS);
            bkt_reg      <= '0;
        end
        else if (state_reg == hbct_pkg::ST_MOD)
        begin
            bkt_reg    <= mod_digit(bkt_reg, blk_sh_reg[BLOCK_W-1 -: 4]);
            blk_sh_reg <= {blk_sh_reg[BLOCK_W-5:0], 4'h0};
        end
        chk_idx_reg <= rd_addr;
        if (chk_vld_reg && (state_reg == hbct_pkg::ST_SCAN))
        begin
            if (match && !hit_found_reg)
            begin
                sel_idx_reg   <= chk_idx_reg;
                sel_refs_reg  <= rd_data.refs;
                sel_valid_reg <= rd_data.valid;
            end
            if (is_free && (!cand_found_reg || (gap < cand_d_reg)))
            begin
                cand_d_reg   <= gap;
                cand_idx_reg <= chk_idx_reg;
            end
        end
        if (load_out)
        begin
            out_slot_reg   <= res_slot;
            out_hit_reg    <= res_hit;
            out_fill_reg   <= res_fill;
            out_status_reg <= res_status;
        end
    end

endmodule

// File: rtl/hbct_checker.sv
// Port-level checks for the hashed buffer cache tag unit, bound to the top level.
// Uses hbct_pkg for payload widths and status codes.
module hbct_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic [hbct_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    input logic [hbct_pkg::S_TUSER_W-1:0]  s_axis_tuser,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [hbct_pkg::M_TDATA_W-1:0]  m_axis_tdata
);

    // one item at a time: intake closes right after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("item accepted while another in flight");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[8:7] == hbct_pkg::STAT_OK) ||
                          (m_axis_tdata[8:7] == hbct_pkg::STAT_NO_FREE) ||
                          (m_axis_tdata[8:7] == hbct_pkg::STAT_UNDERFLOW))
        else $error("undefined status");

    // a miss with nothing free reports slot 0, no hit, no fill
    a_no_free_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[8:7] == hbct_pkg::STAT_NO_FREE)
        |-> (m_axis_tdata[6:0] == 7'd0))
        else $error("no-free result carries slot data");

    a_hit_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[5] |-> (m_axis_tdata[8:7] == hbct_pkg::STAT_OK))
        else $error("hit with error status");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind hashed_buffer_cache_tags_unit hbct_checker u_hbct_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// File: tb/testbench.sv
// Self-checking bench for the hashed buffer cache tag unit: directed rows, then a random mix
// of get, release, pin and unpin items, each checked against a behavioral copy of the tag store.
// Depends on rtl/hbct_pkg.sv and rtl/hashed_buffer_cache_tags_unit.sv.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import hbct_pkg::*;

    localparam int NSLOTS       = DEF_NUM_SLOTS;
    localparam int NBKTS        = DEF_NUM_BUCKETS;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_ITEMS = 1530;
    localparam int TAIL_CYCLES  = 60;
    localparam int HOLD_AT      = 250;    // replies seen before the long receiver hold-off
    localparam int HOLD_LEN     = 400;
    localparam int CALM_FROM    = 700;    // items sent during which neither side idles
    localparam int CALM_TO      = 900;
    localparam int BURST_AT     = 1000;   // start of the pin-to-ceiling burst
    localparam int POOL_N       = 48;
    localparam int MAX_REPORTS  = 40;
    localparam int N_DIRECTED   = 21;

    // one reply of the block, as unpacked from m_axis_tdata
    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              hit;
        logic              fill;
        status_t           status;
    } reply_t;

    // one directed row; typed rows carry their reply, the rest use the tag store copy
    typedef struct packed {
        cmd_t                op;
        logic [DEVICE_W-1:0] device;
        logic [BLOCK_W-1:0]  block;
        logic [SLOT_W-1:0]   slot;
        logic                typed;
        reply_t              reply;
    } row_t;

    localparam reply_t NO_REPLY = '{5'd0, 1'b0, 1'b0, STAT_OK};

    // Walk through the reset tags (device 0, block 0 in every slot), claims, a full bucket,
    // steals with wrap-around, underflow on release and unpin, and a hit at count zero.
    localparam row_t DIRECTED [N_DIRECTED] = '{
        // reset tag of slot 0 matches device 0 block 0: a hit that still needs a fill
        '{CMD_GET,     16'h0000, 32'h0000_0000, 5'd0,  1'b1, '{5'd0,  1'b1, 1'b1, STAT_OK}},
        '{CMD_GET,     16'h0000, 32'h0000_0000, 5'd0,  1'b1, '{5'd0,  1'b1, 1'b0, STAT_OK}},
        // all-ones device and block, then the hit on it
        '{CMD_GET,     16'hFFFF, 32'hFFFF_FFFF, 5'd31, 1'b0, NO_REPLY},
        '{CMD_GET,     16'hFFFF, 32'hFFFF_FFFF, 5'd31, 1'b0, NO_REPLY},
        // bucket 0 fills up, the next claim steals from bucket 1
        '{CMD_GET,     16'h0001, 32'h0000_0000, 5'd0,  1'b0, NO_REPLY},
        '{CMD_GET,     16'h0002, 32'h0000_000D, 5'd0,  1'b0, NO_REPLY},
        '{CMD_GET,     16'h0003, 32'h0000_001A, 5'd0,  1'b0, NO_REPLY},
        // bucket 12 fills up, the steal scan wraps past bucket 0 into bucket 1
        '{CMD_GET,     16'h0004, 32'h0000_000C, 5'd0,  1'b0, NO_REPLY},
        '{CMD_GET,     16'h0005, 32'h0000_0019, 5'd0,  1'b0, NO_REPLY},
        '{CMD_GET,     16'h0006, 32'h0000_0026, 5'd0,  1'b0, NO_REPLY},
        // count underflow on an idle slot, then pin/unpin round trip
        '{CMD_RELEASE, 16'hFFFF, 32'hFFFF_FFFF, 5'd5,  1'b1, '{5'd5,  1'b0, 1'b0, STAT_UNDERFLOW}},
        '{CMD_UNPIN,   16'h0000, 32'h0000_0000, 5'd31, 1'b1, '{5'd31, 1'b0, 1'b0, STAT_UNDERFLOW}},
        '{CMD_PIN,     16'h0000, 32'h0000_0000, 5'd31, 1'b1, '{5'd31, 1'b0, 1'b0, STAT_OK}},
        '{CMD_UNPIN,   16'h0000, 32'h0000_0000, 5'd31, 1'b1, '{5'd31, 1'b0, 1'b0, STAT_OK}},
        // slot 0 back to count zero and one step further
        '{CMD_RELEASE, 16'h0000, 32'h0000_0000, 5'd0,  1'b1, '{5'd0,  1'b0, 1'b0, STAT_OK}},
        '{CMD_UNPIN,   16'h0000, 32'h0000_0000, 5'd0,  1'b1, '{5'd0,  1'b0, 1'b0, STAT_OK}},
        '{CMD_RELEASE, 16'h0000, 32'h0000_0000, 5'd0,  1'b1, '{5'd0,  1'b0, 1'b0, STAT_UNDERFLOW}},
        // a hit ignores the count; then a miss into the now busy bucket 0
        '{CMD_GET,     16'h0000, 32'h0000_0000, 5'd0,  1'b0, NO_REPLY},
        '{CMD_GET,     16'h0007, 32'h0000_0000, 5'd0,  1'b0, NO_REPLY},
        '{CMD_RELEASE, 16'h0000, 32'h0000_0000, 5'd8,  1'b0, NO_REPLY},
        '{CMD_GET,     16'h1234, 32'h8000_0000, 5'd16, 1'b0, NO_REPLY}
    };

    // ------------------------------------------------------------------
    // DUT signals; every input holds a known value from time zero
    // ------------------------------------------------------------------
    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic [S_TUSER_W-1:0] s_axis_tuser = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;

    hashed_buffer_cache_tags_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin : clock_gen
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Behavioral copy of the tag store
    // ------------------------------------------------------------------
    logic [DEVICE_W-1:0] tag_device [NSLOTS];
    logic [BLOCK_W-1:0]  tag_block  [NSLOTS];
    logic [REFS_W-1:0]   tag_refs   [NSLOTS];
    logic                tag_valid  [NSLOTS];
    logic [BUCKET_W-1:0] tag_bucket [NSLOTS];

    reply_t awaited_replies [$];   // replies owed by the block, oldest first

    int n_sent;
    int n_replies;
    int n_errors;
    int n_gets;
    int n_hits;
    int n_fills;
    int n_steals;
    int n_no_free;
    int n_underflows;
    int n_pin_ceiling;
    int n_hold_cycles;

    // lowest free slot of a bucket, -1 when none
    function automatic int first_free_slot(int bkt);
        for (int s = 0; s < NSLOTS; s++)
            if (int'(tag_bucket[s]) == bkt && tag_refs[s] == '0)
                return s;
        return -1;
    endfunction

    // Applies one command to the tag store copy and returns the reply it owes.
    function automatic reply_t tag_lookup(cmd_t op, logic [DEVICE_W-1:0] dev,
                                          logic [BLOCK_W-1:0] blk, logic [SLOT_W-1:0] sin);
        reply_t r;
        int     bkt;
        int     found;
        r = '{sin, 1'b0, 1'b0, STAT_OK};
        found = -1;
        if (op == CMD_GET) begin
            n_gets++;
            bkt = int'(blk % NBKTS);
            for (int s = 0; s < NSLOTS && found < 0; s++)
                if (int'(tag_bucket[s]) == bkt && tag_device[s] == dev && tag_block[s] == blk)
                    found = s;
            if (found >= 0) begin
                // hit: count saturates, the count itself is not looked at
                r.hit = 1'b1;
                n_hits++;
                if (tag_refs[found] != REFS_MAX)
                    tag_refs[found]++;
            end else begin
                // own bucket first, then the others in wrapping order
                for (int i = 0; i < NBKTS && found < 0; i++)
                    found = first_free_slot((bkt + i) % NBKTS);
                if (found < 0) begin
                    n_no_free++;
                    return '{5'd0, 1'b0, 1'b0, STAT_NO_FREE};
                end
                if (int'(tag_bucket[found]) != bkt)
                    n_steals++;
                tag_device[found] = dev;
                tag_block[found]  = blk;
                tag_refs[found]   = 1;
                tag_valid[found]  = 1'b0;
                tag_bucket[found] = BUCKET_W'(bkt);
            end
            r.slot = SLOT_W'(found);
            r.fill = !tag_valid[found];
            if (r.fill)
                n_fills++;
            tag_valid[found] = 1'b1;
        end else if (int'(sin) < NSLOTS) begin
            if (op == CMD_PIN) begin
                if (tag_refs[sin] == REFS_MAX)
                    n_pin_ceiling++;
                else
                    tag_refs[sin]++;
            end else if (tag_refs[sin] == '0) begin
                // release and unpin at count zero
                r.status = STAT_UNDERFLOW;
                n_underflows++;
            end else begin
                tag_refs[sin]--;
            end
        end
        return r;
    endfunction

    // a slot that currently holds references, or any slot when none does
    function automatic logic [SLOT_W-1:0] pick_held_slot();
        int held [$];
        for (int s = 0; s < NSLOTS; s++)
            if (tag_refs[s] != '0)
                held.push_back(s);
        if (held.size() == 0)
            return SLOT_W'($urandom_range(NSLOTS - 1));
        return SLOT_W'(held[$urandom_range(held.size() - 1)]);
    endfunction

    // no idling on either side while this holds
    function automatic bit calm_stretch();
        return n_sent >= CALM_FROM && n_sent < CALM_TO;
    endfunction

    // ------------------------------------------------------------------
    // Command side: optional idle gap, offer the item, wait for the
    // handshake, then book the reply it owes.
    // ------------------------------------------------------------------
    task automatic issue(cmd_t op, logic [DEVICE_W-1:0] dev, logic [BLOCK_W-1:0] blk,
                         logic [SLOT_W-1:0] sin, bit typed = 1'b0,
                         reply_t typed_reply = NO_REPLY);
        reply_t predicted;
        while (!calm_stretch() && $urandom_range(99) < 14) begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, sin, blk, dev};
        s_axis_tuser  <= op;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predicted = tag_lookup(op, dev, blk, sin);
        awaited_replies.push_back(typed ? typed_reply : predicted);
        n_sent++;
    endtask

    task automatic flag_field(string field, int want, int got);
        n_errors++;
        if (n_errors <= MAX_REPORTS)
            $display("%0t: reply %0d %s expected %0d, got %0d",
                     $time, n_replies, field, want, got);
    endtask

    // ------------------------------------------------------------------
    // Result side: check every accepted reply against the oldest one owed,
    // stall at random, and once hold off long enough to back up the input.
    // ------------------------------------------------------------------
    initial begin : reply_checker
        reply_t want;
        int     hold_left;
        bit     held;
        hold_left = 0;
        held = 1'b0;
        forever begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready) begin
                if (awaited_replies.size() == 0) begin
                    n_errors++;
                    if (n_errors <= MAX_REPORTS)
                        $display("%0t: reply with nothing outstanding, expected none, got 0x%h",
                                 $time, m_axis_tdata);
                end else begin
                    want = awaited_replies.pop_front();
                    if (m_axis_tdata[4:0] != want.slot)
                        flag_field("slot_out", int'(want.slot), int'(m_axis_tdata[4:0]));
                    if (m_axis_tdata[5] != want.hit)
                        flag_field("hit", int'(want.hit), int'(m_axis_tdata[5]));
                    if (m_axis_tdata[6] != want.fill)
                        flag_field("needs_fill", int'(want.fill), int'(m_axis_tdata[6]));
                    if (m_axis_tdata[8:7] != want.status)
                        flag_field("status", int'(want.status), int'(m_axis_tdata[8:7]));
                end
                n_replies++;
            end
            if (hold_left > 0) begin
                hold_left--;
                n_hold_cycles++;
                m_axis_tready <= 1'b0;
            end else if (!held && n_replies >= HOLD_AT) begin
                held = 1'b1;
                hold_left = HOLD_LEN;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= calm_stretch() || $urandom_range(99) >= 14;
            end
        end
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("%0t: no completion after %0d cycles", $time, cycles);
        $display("hashed_buffer_cache_tags_unit test failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        logic [DEVICE_W-1:0] pool_dev [POOL_N];
        logic [BLOCK_W-1:0]  pool_blk [POOL_N];
        logic [DEVICE_W-1:0] dev;
        logic [BLOCK_W-1:0]  blk;
        logic [SLOT_W-1:0]   sin;
        cmd_t                op;
        int                  phase;
        int                  left_in_phase;
        int                  pick;
        int                  r;
        bit                  burst_done;

        for (int s = 0; s < NSLOTS; s++) begin
            tag_device[s] = '0;
            tag_block[s]  = '0;
            tag_refs[s]   = '0;
            tag_valid[s]  = 1'b0;
            tag_bucket[s] = BUCKET_W'(s % NBKTS);
        end

        // Pool of tags that come back often, so that hits are common. A third are small
        // block numbers crowded into a few buckets to force steals; the rest span 32 bits.
        for (int p = 0; p < POOL_N; p++) begin
            pool_dev[p] = (p % 4 == 0) ? DEVICE_W'($urandom_range(3)) : DEVICE_W'($urandom);
            pool_blk[p] = (p % 3 == 0) ? BLOCK_W'($urandom_range(2) + NBKTS * $urandom_range(3))
                                       : BLOCK_W'($urandom);
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIRECTED; i++)
            issue(DIRECTED[i].op, DIRECTED[i].device, DIRECTED[i].block, DIRECTED[i].slot,
                  DIRECTED[i].typed, DIRECTED[i].reply);

        // Random part in phases: normal traffic, fill (mostly gets, runs the store out of
        // free slots) and drain (mostly releases and unpins). Unused fields carry random bits.
        phase = 0;
        left_in_phase = 0;
        burst_done = 1'b0;
        while (n_sent < N_DIRECTED + RANDOM_ITEMS) begin
            if (!burst_done && n_sent >= BURST_AT) begin
                // drive one slot into the count ceiling, hit it there, then unwind it
                burst_done = 1'b1;
                sin = pick_held_slot();
                repeat (int'(REFS_MAX) + 3)
                    issue(CMD_PIN, DEVICE_W'($urandom), BLOCK_W'($urandom), sin);
                repeat (3)
                    issue(CMD_GET, tag_device[sin], tag_block[sin], SLOT_W'($urandom));
                repeat (int'(REFS_MAX) + 8)
                    issue($urandom_range(1) ? CMD_RELEASE : CMD_UNPIN,
                          DEVICE_W'($urandom), BLOCK_W'($urandom), sin);
            end
            if (left_in_phase == 0) begin
                pick = $urandom_range(9);
                phase = (pick < 5) ? 0 : (pick < 8) ? 1 : 2;
                left_in_phase = $urandom_range(120, 40);
            end
            left_in_phase--;

            dev = DEVICE_W'($urandom);
            blk = BLOCK_W'($urandom);
            sin = SLOT_W'($urandom);
            r = $urandom_range(99);
            op = CMD_GET;
            case (phase)
                0: begin
                    if (r < 45) begin
                        op = CMD_GET;
                        if (r < 32) begin
                            pick = $urandom_range(POOL_N - 1);
                            dev = pool_dev[pick];
                            blk = pool_blk[pick];
                        end
                    end else if (r < 70) begin
                        op = CMD_RELEASE;
                        sin = pick_held_slot();
                    end else if (r < 80) begin
                        op = CMD_PIN;
                        sin = pick_held_slot();
                    end else if (r < 92) begin
                        op = CMD_UNPIN;
                        sin = pick_held_slot();
                    end else begin
                        op = cmd_t'($urandom_range(3));   // noise on any slot
                    end
                end
                1: begin
                    if (r < 85) begin
                        op = CMD_GET;
                        if (r < 40) begin
                            pick = $urandom_range(POOL_N - 1);
                            dev = pool_dev[pick];
                            blk = pool_blk[pick];
                        end
                    end else begin
                        op = CMD_PIN;
                        sin = pick_held_slot();
                    end
                end
                default: begin
                    if (r < 45) begin
                        op = CMD_RELEASE;
                        sin = pick_held_slot();
                    end else if (r < 75) begin
                        op = CMD_UNPIN;
                        sin = pick_held_slot();
                    end else begin
                        op = CMD_GET;
                        pick = $urandom_range(POOL_N - 1);
                        dev = pool_dev[pick];
                        blk = pool_blk[pick];
                    end
                end
            endcase
            issue(op, dev, blk, sin);
        end
        s_axis_tvalid <= 1'b0;

        // let every owed reply arrive, then watch a while for strays
        while (awaited_replies.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Ran %0d items: %0d gets with %0d hits, %0d fills, %0d steals, %0d no-free.",
                 n_sent, n_gets, n_hits, n_fills, n_steals, n_no_free);
        $display("Also %0d count underflows, %0d pins at the ceiling, %0d cycles of hold-off.",
                 n_underflows, n_pin_ceiling, n_hold_cycles);
        if (n_errors == 0)
            $display("hashed_buffer_cache_tags_unit test passed");
        else
            $display("hashed_buffer_cache_tags_unit test failed");
        $finish;
    end

endmodule
